FILE: src/sparse_dfa_token_matcher_core_defines.svh
// Assertion macros shared by the sparse automaton matcher modules.
`ifndef SPARSE_DFA_TOKEN_MATCHER_CORE_DEFINES_SVH
`define SPARSE_DFA_TOKEN_MATCHER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
// The module must have signals named clk and rst_n.
`define SDTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SDTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sdtm_pkg.sv
// Shared types and constants of the sparse automaton token matcher.
package sdtm_pkg;

    // Fixed field widths of the stream items.
    localparam int SLOT_W   = 12;
    localparam int CLASS_W  = 5;
    localparam int COUNT_W  = 7;
    localparam int SYMBOL_W = 8;
    localparam int TSTATE_W = 8;
    localparam int CFG_W    = 9;

    // Number of classified commands held between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_STATE_WR = 2'd0,
        OP_EDGE_WR  = 2'd1,
        OP_CONSUME  = 2'd2,
        OP_FINISH   = 2'd3
    } op_t;

    // Command kinds after classification in the front end.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_STATE_WR,
        KIND_EDGE_WR,
        KIND_CONSUME,
        KIND_FINISH
    } kind_t;

    // Classified command passed through the queue.
    typedef struct packed {
        kind_t                kind;
        logic [SLOT_W-1:0]    slot;
        logic [CLASS_W-1:0]   cls;
        logic [SLOT_W-1:0]    base;
        logic [COUNT_W-1:0]   count;
        logic [SYMBOL_W-1:0]  symbol;
        logic [TSTATE_W-1:0]  target;
    } sdtm_cmd_t;

    // One result item.
    typedef struct packed {
        logic [TSTATE_W-1:0]  current_state;
        logic                 dead;
        logic [CLASS_W-1:0]   token_class;
        logic                 end_of_string;
    } sdtm_result_t;

    // Sequencer states of the back end.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RECORD,
        BK_PROBE,
        BK_EMIT
    } back_state_t;

endpackage

FILE: src/sdtm_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
`include "sparse_dfa_token_matcher_core_defines.svh"

module sdtm_front
    import sdtm_pkg::*;
#(
    parameter int STATE_DEPTH = 256,
    parameter int EDGE_DEPTH  = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[11:0], class_bits[16:12], first_entry[28:17], entry_count[35:29],
    // symbol[43:36], next_state[51:44], zero fill[55:52]
    input  logic [55:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        q_valid,
    output sdtm_cmd_t   q_cmd,
    input  logic        q_pop
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int QC = QW + 1;
    localparam logic [QC-1:0] FULL_COUNT = QC'(QUEUE_DEPTH);

    sdtm_cmd_t       queue_mem [QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg;
    logic [QW-1:0]   wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg;
    logic [QW-1:0]   rd_ptr_next;
    logic [QC-1:0]   count_reg;
    logic [QC-1:0]   count_next;
    sdtm_cmd_t       cmd_in;
    logic            accept;
    logic            push;

    // Unpack the payload and classify the operation. Writes to slots
    // beyond a store are dropped here.
    always_comb
    begin
        cmd_in.slot   = s_tdata[11:0];
        cmd_in.cls    = s_tdata[16:12];
        cmd_in.base   = s_tdata[28:17];
        cmd_in.count  = s_tdata[35:29];
        cmd_in.symbol = s_tdata[43:36];
        cmd_in.target = s_tdata[51:44];
        case (op_t'(s_tuser))
            OP_STATE_WR:
            begin
                cmd_in.kind = (13'(s_tdata[11:0]) < 13'(STATE_DEPTH)) ?
                              KIND_STATE_WR : KIND_NONE;
            end
            OP_EDGE_WR:
            begin
                cmd_in.kind = (17'(s_tdata[11:0]) < 17'(EDGE_DEPTH)) ?
                              KIND_EDGE_WR : KIND_NONE;
            end
            OP_CONSUME: cmd_in.kind = KIND_CONSUME;
            OP_FINISH:  cmd_in.kind = KIND_FINISH;
            default:    cmd_in.kind = KIND_NONE;
        endcase
    end

    // Handshake and queue bookkeeping.
    assign s_tready = (count_reg != FULL_COUNT);
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (cmd_in.kind != KIND_NONE);
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QC'(push) - QC'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    `SDTM_ASSERT_NOW(a_pop_nonempty, q_pop, count_reg != '0, "pop from an empty queue")
    `SDTM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "queue count overflow")
    `SDTM_ASSERT_NEXT(a_count_grows, push && !q_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

FILE: src/sdtm_back.sv
// Back end: table stores, binary search sequencer and result register.
`include "sparse_dfa_token_matcher_core_defines.svh"

module sdtm_back
    import sdtm_pkg::*;
#(
    parameter int STATE_DEPTH = 256,
    parameter int EDGE_DEPTH  = 4096,
    parameter int MAX_EDGES   = 127,
    parameter int CLASS_BITS  = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              q_valid,
    input  sdtm_cmd_t         q_cmd,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sdtm_result_t      res
);

    localparam int SW = $clog2(STATE_DEPTH);
    localparam int EW = $clog2(EDGE_DEPTH);
    localparam int AW = ((EW > SLOT_W) ? EW : SLOT_W) + 1;
    localparam int CW = (CLASS_BITS < CLASS_W) ? CLASS_BITS : CLASS_W;

    // Table stores.
    logic [CW-1:0]       cls_mem    [STATE_DEPTH];
    logic [SLOT_W-1:0]   base_mem   [STATE_DEPTH];
    logic [COUNT_W-1:0]  size_mem   [STATE_DEPTH];
    logic [SYMBOL_W-1:0] esym_mem   [EDGE_DEPTH];
    logic [TSTATE_W-1:0] etgt_mem   [EDGE_DEPTH];

    logic [CW-1:0]       cls_q;
    logic [SLOT_W-1:0]   base_q;
    logic [COUNT_W-1:0]  size_q;
    logic [SYMBOL_W-1:0] esym_q;
    logic [TSTATE_W-1:0] etgt_q;

    logic                rec_wr_en;
    logic                rec_rd_en;
    logic [SW-1:0]       rec_rd_addr;
    logic                edge_wr_en;
    logic                edge_rd_en;
    logic [EW-1:0]       edge_rd_addr;

    // Sequencer and automaton registers.
    back_state_t         state_reg;
    back_state_t         state_next;
    logic [CFG_W-1:0]    state_count_reg;
    logic [TSTATE_W-1:0] active_reg;
    logic [TSTATE_W-1:0] active_next;
    logic                dead_reg;
    logic                dead_next;
    logic                eos_reg;
    logic                eos_next;
    logic [SYMBOL_W-1:0] sym_reg;
    logic [SYMBOL_W-1:0] sym_next;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       base_next;
    logic [COUNT_W-1:0]  n_reg;
    logic [COUNT_W-1:0]  n_next;

    // Result register.
    logic                out_valid_reg;
    logic                out_valid_next;
    sdtm_result_t        out_reg;
    sdtm_result_t        out_next;

    // Search arithmetic.
    logic [12:0]         lim;
    logic [COUNT_W-1:0]  n_cap;
    logic [AW-1:0]       base_ext;
    logic [AW-1:0]       room;
    logic [COUNT_W-1:0]  n_clip;
    logic [COUNT_W-1:0]  half_cur;
    logic [AW-1:0]       nb;
    logic [COUNT_W-1:0]  nn;

    // Usable state count is the configured count capped at the store depth.
    assign lim = (13'(state_count_reg) < 13'(STATE_DEPTH)) ?
                 13'(state_count_reg) : 13'(STATE_DEPTH);

    // Slice of the fetched state record, saturated and cut at the store end.
    always_comb
    begin
        n_cap    = (8'(size_q) > 8'(MAX_EDGES)) ? COUNT_W'(MAX_EDGES) : size_q;
        base_ext = AW'(base_q);
        room     = AW'(EDGE_DEPTH) - base_ext;
        if (base_ext >= AW'(EDGE_DEPTH))
        begin
            n_clip = '0;
        end
        else if (AW'(n_cap) > room)
        begin
            n_clip = COUNT_W'(room);
        end
        else
        begin
            n_clip = n_cap;
        end
    end

    // Narrow the search window after a probe that did not match.
    always_comb
    begin
        half_cur = n_reg >> 1;
        if (esym_q < sym_reg)
        begin
            nb = base_reg + AW'(half_cur) + AW'(1);
            nn = n_reg - half_cur - COUNT_W'(1);
        end
        else
        begin
            nb = base_reg;
            nn = half_cur;
        end
    end

    // Sequencer: next state, store accesses and result loading.
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        dead_next      = dead_reg;
        eos_next       = eos_reg;
        sym_next       = sym_reg;
        base_next      = base_reg;
        n_next         = n_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        rec_wr_en      = 1'b0;
        rec_rd_en      = 1'b0;
        rec_rd_addr    = SW'(active_reg);
        edge_wr_en     = 1'b0;
        edge_rd_en     = 1'b0;
        edge_rd_addr   = EW'(base_ext + AW'(n_clip >> 1));

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        KIND_STATE_WR: rec_wr_en  = 1'b1;
                        KIND_EDGE_WR:  edge_wr_en = 1'b1;
                        KIND_CONSUME:
                        begin
                            sym_next = q_cmd.symbol;
                            eos_next = 1'b0;
                            if (dead_reg)
                            begin
                                state_next = BK_EMIT;
                            end
                            else if (13'(active_reg) >= lim)
                            begin
                                dead_next   = 1'b1;
                                active_next = '0;
                                state_next  = BK_EMIT;
                            end
                            else
                            begin
                                rec_rd_en  = 1'b1;
                                state_next = BK_RECORD;
                            end
                        end
                        KIND_FINISH:
                        begin
                            eos_next   = 1'b1;
                            rec_rd_en  = 1'b1;
                            state_next = BK_EMIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            BK_RECORD:
            begin
                // First probe goes to the middle of the whole slice.
                if (n_clip == '0)
                begin
                    dead_next   = 1'b1;
                    active_next = '0;
                    state_next  = BK_EMIT;
                end
                else
                begin
                    edge_rd_en = 1'b1;
                    base_next  = base_ext;
                    n_next     = n_clip;
                    state_next = BK_PROBE;
                end
            end

            BK_PROBE:
            begin
                if (esym_q == sym_reg)
                begin
                    if (13'(etgt_q) >= lim)
                    begin
                        dead_next   = 1'b1;
                        active_next = '0;
                    end
                    else
                    begin
                        active_next = etgt_q;
                        rec_rd_en   = 1'b1;
                        rec_rd_addr = SW'(etgt_q);
                    end
                    state_next = BK_EMIT;
                end
                else if (nn == '0)
                begin
                    dead_next   = 1'b1;
                    active_next = '0;
                    state_next  = BK_EMIT;
                end
                else
                begin
                    // Next probe is issued in the same cycle as the compare.
                    edge_rd_en   = 1'b1;
                    edge_rd_addr = EW'(nb + AW'(nn >> 1));
                    base_next    = nb;
                    n_next       = nn;
                end
            end

            BK_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next.current_state = active_reg;
                    out_next.dead          = dead_reg;
                    out_next.token_class   = dead_reg ? '0 : CLASS_W'(cls_q);
                    out_next.end_of_string = eos_reg;
                    out_valid_next         = 1'b1;
                    if (eos_reg)
                    begin
                        active_next = '0;
                        dead_next   = 1'b0;
                    end
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            state_count_reg <= CFG_W'(1);
            active_reg      <= '0;
            dead_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            dead_reg      <= dead_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                state_count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        eos_reg  <= eos_next;
        sym_reg  <= sym_next;
        base_reg <= base_next;
        n_reg    <= n_next;
        out_reg  <= out_next;
    end

    // State record store with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (rec_wr_en)
        begin
            cls_mem[SW'(q_cmd.slot)]  <= CW'(q_cmd.cls);
            base_mem[SW'(q_cmd.slot)] <= q_cmd.base;
            size_mem[SW'(q_cmd.slot)] <= q_cmd.count;
        end
        if (rec_rd_en)
        begin
            cls_q  <= cls_mem[rec_rd_addr];
            base_q <= base_mem[rec_rd_addr];
            size_q <= size_mem[rec_rd_addr];
        end
    end

    // Transition store with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (edge_wr_en)
        begin
            esym_mem[EW'(q_cmd.slot)] <= q_cmd.symbol;
            etgt_mem[EW'(q_cmd.slot)] <= q_cmd.target;
        end
        if (edge_rd_en)
        begin
            esym_q <= esym_mem[edge_rd_addr];
            etgt_q <= etgt_mem[edge_rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;

    `SDTM_ASSERT_NOW(a_dead_state_zero, dead_reg, active_reg == '0, "dead string not in state zero")
    `SDTM_ASSERT_NOW(a_probe_nonempty, state_reg == BK_PROBE, n_reg != '0, "probe on an empty window")
    `SDTM_ASSERT_NEXT(a_emit_waits, (state_reg == BK_EMIT) && out_valid_reg && !m_tready, state_reg == BK_EMIT, "result dropped while output stalled")

endmodule

FILE: src/sparse_dfa_token_matcher_core.sv
// Top level of the sparse table-driven automaton token matcher.
//
// Usage: the input stream carries one operation per transaction, selected by
// s_tuser: write a state record, write a transition entry, consume a
// character or finish a string. Table writes give no result. Each consume
// and each finish gives one result transaction on the output stream with
// the new state, the dead flag and the token class; m_tlast marks the result
// of a finish. The user must write the state count register via cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
// Timing: a front end queues up to four commands. The back end takes a
// table write in its idle step alone; a finish, or a consume on a dead string
// or from a state out of use, in its idle and emit steps; any other consume in
// its idle and record steps, p binary search probes (0 to 7 for up to 127
// transitions), one per cycle through the single read port of the transition
// store, and its emit step. The emit step loads the result into the output register.
// Reset: the automaton returns to state 0, not dead, state count 1; the
// table stores hold nothing defined until written.
// Stall: a result waits in the output register; the back end stops in its
// emit step, the queue fills and then s_tready drops.
module sparse_dfa_token_matcher_core
    import sdtm_pkg::*;
#(
    parameter int STATE_DEPTH = 256,
    parameter int EDGE_DEPTH  = 4096,
    parameter int MAX_EDGES   = 127,
    parameter int CLASS_BITS  = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[11:0], class_bits[16:12], first_entry[28:17], entry_count[35:29],
    // symbol[43:36], next_state[51:44], zero fill[55:52]
    input  logic [55:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // current_state[7:0], dead[8], token_class[13:9], zero fill[15:14]
    output logic [15:0] m_tdata,
    // end_of_string
    output logic        m_tlast
);

    logic         q_valid;
    logic         q_pop;
    sdtm_cmd_t    q_cmd;
    sdtm_result_t res;

    // Front end with the command queue.
    sdtm_front #(
        .STATE_DEPTH (STATE_DEPTH),
        .EDGE_DEPTH  (EDGE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // Back end with the stores and the search sequencer.
    sdtm_back #(
        .STATE_DEPTH (STATE_DEPTH),
        .EDGE_DEPTH  (EDGE_DEPTH),
        .MAX_EDGES   (MAX_EDGES),
        .CLASS_BITS  (CLASS_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    // Pack the result onto the output stream.
    assign m_tdata = {2'b00, res.token_class, res.dead, res.current_state};
    assign m_tlast = res.end_of_string;

endmodule
